[rtl/multichannel_moving_average_macros.svh]
// Assertion macros shared by the moving average RTL.
`ifndef MULTICHANNEL_MOVING_AVERAGE_MACROS_SVH
`define MULTICHANNEL_MOVING_AVERAGE_MACROS_SVH

// Same-cycle implication, checked on clk and disabled while arst_n is low.
`define MMA_ASSERT_NOW(label, ante, cons, msg) \
	label: assert property (@(posedge clk) disable iff (!arst_n) (ante) |-> (cons)) \
		else $error(msg);

// Next-cycle implication, checked on clk and disabled while arst_n is low.
`define MMA_ASSERT_NEXT(label, ante, cons, msg) \
	label: assert property (@(posedge clk) disable iff (!arst_n) (ante) |=> (cons)) \
		else $error(msg);

`endif

[rtl/mma_pkg.sv]
// Shared constants and helper functions of the multichannel moving average.
package mma_pkg;

	localparam int CHANNELS_DEF    = 4;
	localparam int MAX_WINDOW_DEF  = 32;
	localparam int SAMPLE_BITS_DEF = 16;

	localparam int CH_FIELD_W   = 2;
	localparam int NUM_WIN_REGS = 4;
	localparam int WIN_REG_W    = 6;
	localparam int WIN_RESET    = 1;
	localparam int REG_IDX_W    = 2;
	localparam int PADDR_W      = 4;
	localparam int PDATA_W      = 32;

	// Bits needed to hold a window length from 0 up to and including max_window.
	function automatic int win_width(input int max_window);
		return $clog2(max_window + 1);
	endfunction

	// Bits of an exact running sum of max_window samples.
	function automatic int sum_width(input int sample_bits, input int max_window);
		return sample_bits + $clog2(max_window);
	endfunction

endpackage

[rtl/multichannel_moving_average.sv]
// Per-channel boxcar moving average over a sample stream. Each transaction carries a
// channel number and a signed sample; every accepted transaction yields exactly one
// result transaction with the same channel. Channel c averages its last window_ch<c>
// samples (values above MAX_WINDOW act as MAX_WINDOW), truncating toward zero; a
// window of zero, or a channel at or above CHANNELS, passes the sample through. The
// block handles one transaction at a time. A filtered transaction's result comes from
// the bit-serial divider that produces one quotient bit per cycle, SUM_W bits in all
// (SUM_W = SAMPLE_BITS + clog2(MAX_WINDOW)); a pass-through transaction skips the
// history read and the divider. The next transaction is accepted once the result
// sits in the output register. History lives in a RAM with no clearing pass: an entry
// reads as zero until the channel's write pointer has wrapped once since reset or
// since the last write of that channel's window register, which also clears the
// channel's running sum.
`include "multichannel_moving_average_macros.svh"

module multichannel_moving_average #(
	parameter int CHANNELS    = mma_pkg::CHANNELS_DEF,
	parameter int MAX_WINDOW  = mma_pkg::MAX_WINDOW_DEF,
	parameter int SAMPLE_BITS = mma_pkg::SAMPLE_BITS_DEF
) (
	input  logic                            clk,
	input  logic                            arst_n,
	input  logic                            psel,
	input  logic                            penable,
	input  logic                            pwrite,
	input  logic [mma_pkg::PADDR_W-1:0]     paddr,
	input  logic [mma_pkg::PDATA_W-1:0]     pwdata,
	output logic [mma_pkg::PDATA_W-1:0]     prdata,
	output logic                            pready,
	input  logic                            in_valid,
	output logic                            in_stall,
	input  logic [mma_pkg::CH_FIELD_W-1:0]  channel,
	input  logic signed [SAMPLE_BITS-1:0]   sample,
	output logic                            out_valid,
	input  logic                            out_stall,
	output logic [mma_pkg::CH_FIELD_W-1:0]  out_channel,
	output logic signed [SAMPLE_BITS-1:0]   average
);

	import mma_pkg::*;

	localparam int SB    = SAMPLE_BITS;
	localparam int WIN_W = win_width(MAX_WINDOW);
	localparam int SUM_W = sum_width(SAMPLE_BITS, MAX_WINDOW);
	localparam int PTR_W = $clog2(MAX_WINDOW);
	localparam int CH_W  = (CHANNELS > 1) ? $clog2(CHANNELS) : 1;
	localparam int DEPTH = CHANNELS * MAX_WINDOW;
	localparam int HA_W  = $clog2(DEPTH);

	typedef enum logic [5:0] {
		ST_IDLE  = 6'b000001,
		ST_READ  = 6'b000010,
		ST_SUM   = 6'b000100,
		ST_DIVGO = 6'b001000,
		ST_DIV   = 6'b010000,
		ST_OUT   = 6'b100000
	} state_t;

	state_t state_q;

	// Configuration registers.
	logic [WIN_REG_W-1:0] win_q [NUM_WIN_REGS];
	logic                 cfg_wr;
	logic [REG_IDX_W-1:0] cfg_idx;

	// Per-channel filter state.
	logic signed [SUM_W-1:0] sum_q  [CHANNELS];
	logic [PTR_W-1:0]        ptr_q  [CHANNELS];
	logic                    wrap_q [CHANNELS];

	// Transaction being worked on.
	logic [CH_FIELD_W-1:0]  ch_q;
	logic [CH_W-1:0]        idx_q;
	logic [WIN_W-1:0]       w_q;
	logic [PTR_W-1:0]       p_q;
	logic [HA_W-1:0]        addr_q;
	logic signed [SB-1:0]   sample_q;
	logic signed [SB:0]     diff_q;
	logic signed [SB-1:0]   result_q;

	// Output register.
	logic                   out_valid_q;
	logic [CH_FIELD_W-1:0]  out_channel_q;
	logic signed [SB-1:0]   average_q;

	logic                   in_acc;
	logic                   out_free;
	logic [CH_W-1:0]        ch_in_idx;
	logic [WIN_W-1:0]       w_in;
	logic                   filt_in;
	logic [PTR_W-1:0]       ptr_in;
	logic [PTR_W-1:0]       p_in;
	logic [HA_W-1:0]        rd_addr;
	logic [SB-1:0]          rd_data;
	logic signed [SB-1:0]   old_smp;
	logic [WIN_W-1:0]       p_inc;
	logic                   div_start;
	logic                   div_done;
	logic signed [SB-1:0]   div_quot;

	assign pready   = 1'b1;
	assign cfg_wr   = psel & penable & pwrite;
	assign cfg_idx  = paddr[PADDR_W-1:2];
	assign prdata   = PDATA_W'(win_q[cfg_idx]);

	assign in_stall = (state_q != ST_IDLE);
	assign in_acc   = in_valid & ~in_stall;
	assign out_free = ~out_valid_q | ~out_stall;

	always_comb begin
		ch_in_idx = CH_W'(channel);
		if (int'(win_q[channel]) > MAX_WINDOW) begin
			w_in = WIN_W'(MAX_WINDOW);
		end else begin
			w_in = WIN_W'(win_q[channel]);
		end
		filt_in = (int'(channel) < CHANNELS) && (w_in != '0);
		ptr_in  = ptr_q[ch_in_idx];
		p_in    = (WIN_W'(ptr_in) >= w_in) ? '0 : ptr_in;
		rd_addr = HA_W'(int'(ch_in_idx) * MAX_WINDOW) + HA_W'(p_in);
		old_smp = wrap_q[idx_q] ? $signed(rd_data) : '0;
		p_inc   = WIN_W'(p_q) + 1'b1;
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			state_q <= ST_IDLE;
		end else begin
			case (state_q)
				ST_IDLE: begin
					if (in_acc) begin
						state_q <= filt_in ? ST_READ : ST_OUT;
					end
				end
				ST_READ: begin
					state_q <= ST_SUM;
				end
				ST_SUM: begin
					state_q <= ST_DIVGO;
				end
				ST_DIVGO: begin
					state_q <= ST_DIV;
				end
				ST_DIV: begin
					if (div_done) begin
						state_q <= ST_OUT;
					end
				end
				ST_OUT: begin
					if (out_free) begin
						state_q <= ST_IDLE;
					end
				end
				default: begin
					state_q <= ST_IDLE;
				end
			endcase
		end
	end

	// Window registers and per-channel state; a window write restarts its channel.
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			for (int i = 0; i < NUM_WIN_REGS; i++) begin
				win_q[i] <= WIN_REG_W'(WIN_RESET);
			end
			for (int c = 0; c < CHANNELS; c++) begin
				sum_q[c]  <= '0;
				ptr_q[c]  <= '0;
				wrap_q[c] <= 1'b0;
			end
		end else begin
			if (cfg_wr) begin
				win_q[cfg_idx] <= pwdata[WIN_REG_W-1:0];
				for (int c = 0; c < CHANNELS; c++) begin
					if (int'(cfg_idx) == c) begin
						sum_q[c]  <= '0;
						ptr_q[c]  <= '0;
						wrap_q[c] <= 1'b0;
					end
				end
			end
			if (state_q == ST_READ) begin
				if (p_inc >= w_q) begin
					ptr_q[idx_q]  <= '0;
					wrap_q[idx_q] <= 1'b1;
				end else begin
					ptr_q[idx_q] <= PTR_W'(p_inc);
				end
			end
			if (state_q == ST_SUM) begin
				sum_q[idx_q] <= sum_q[idx_q] + SUM_W'(diff_q);
			end
		end
	end

	always_ff @(posedge clk) begin
		if (in_acc) begin
			ch_q     <= channel;
			idx_q    <= ch_in_idx;
			w_q      <= w_in;
			p_q      <= p_in;
			addr_q   <= rd_addr;
			sample_q <= sample;
			result_q <= sample;
		end
		if (state_q == ST_READ) begin
			diff_q <= (SB+1)'(sample_q) - (SB+1)'(old_smp);
		end
		if ((state_q == ST_DIV) && div_done) begin
			result_q <= div_quot;
		end
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			out_valid_q <= 1'b0;
		end else begin
			if ((state_q == ST_OUT) && out_free) begin
				out_valid_q <= 1'b1;
			end else if (~out_stall) begin
				out_valid_q <= 1'b0;
			end
		end
	end

	always_ff @(posedge clk) begin
		if ((state_q == ST_OUT) && out_free) begin
			out_channel_q <= ch_q;
			average_q     <= result_q;
		end
	end

	assign out_valid   = out_valid_q;
	assign out_channel = out_channel_q;
	assign average     = average_q;

	assign div_start = (state_q == ST_DIVGO);

	mma_hist_ram #(
		.DEPTH (DEPTH),
		.WIDTH (SB),
		.AW    (HA_W)
	) u_hist (
		.clk     (clk),
		.rd_en   (in_acc & filt_in),
		.rd_addr (rd_addr),
		.rd_data (rd_data),
		.wr_en   (state_q == ST_READ),
		.wr_addr (addr_q),
		.wr_data (sample_q)
	);

	mma_serial_div #(
		.SB    (SB),
		.SUM_W (SUM_W),
		.WIN_W (WIN_W)
	) u_div (
		.clk      (clk),
		.arst_n   (arst_n),
		.start    (div_start),
		.dividend (sum_q[idx_q]),
		.divisor  (w_q),
		.done     (div_done),
		.quotient (div_quot)
	);

	`MMA_ASSERT_NOW(a_read_window, state_q == ST_READ, w_q != '0, "filter path with zero window")
	`MMA_ASSERT_NOW(a_done_in_div, div_done, state_q == ST_DIV, "divider finished out of turn")
	`MMA_ASSERT_NOW(a_ptr_bound, state_q == ST_SUM, WIN_W'(ptr_q[idx_q]) < w_q, "pointer past window")

endmodule

[rtl/mma_hist_ram.sv]
// Sample history memory: one write port, one registered read port.
module mma_hist_ram #(
	parameter int DEPTH = 128,
	parameter int WIDTH = 16,
	parameter int AW    = 7
) (
	input  logic             clk,
	input  logic             rd_en,
	input  logic [AW-1:0]    rd_addr,
	output logic [WIDTH-1:0] rd_data,
	input  logic             wr_en,
	input  logic [AW-1:0]    wr_addr,
	input  logic [WIDTH-1:0] wr_data
);

	logic [WIDTH-1:0] mem_q [DEPTH];
	logic [WIDTH-1:0] rd_data_q;

	always_ff @(posedge clk) begin
		if (wr_en) begin
			mem_q[wr_addr] <= wr_data;
		end
	end

	always_ff @(posedge clk) begin
		if (rd_en) begin
			rd_data_q <= mem_q[rd_addr];
		end
	end

	assign rd_data = rd_data_q;

endmodule

[rtl/mma_serial_div.sv]
// Bit-serial restoring divider: signed running sum over unsigned window, truncated toward zero.
`include "multichannel_moving_average_macros.svh"

module mma_serial_div #(
	parameter int SB    = 16,
	parameter int SUM_W = 21,
	parameter int WIN_W = 6
) (
	input  logic                    clk,
	input  logic                    arst_n,
	input  logic                    start,
	input  logic signed [SUM_W-1:0] dividend,
	input  logic [WIN_W-1:0]        divisor,
	output logic                    done,
	output logic signed [SB-1:0]    quotient
);

	import mma_pkg::*;

	localparam int CNT_W = $clog2(SUM_W + 1);

	typedef enum logic [2:0] {
		DV_IDLE = 3'b001,
		DV_RUN  = 3'b010,
		DV_FIN  = 3'b100
	} dv_state_t;

	dv_state_t        dv_state_q;
	logic [CNT_W-1:0] cnt_q;
	logic             done_q;
	logic             sign_q;
	logic [WIN_W-1:0] rem_q;
	logic [WIN_W-1:0] div_q;
	logic [SUM_W-1:0] quo_q;
	logic [SB-1:0]    quotient_q;

	logic [WIN_W:0]   shifted;
	logic [WIN_W:0]   trial;
	logic [WIN_W-1:0] rem_nxt;
	logic             quo_bit;
	logic [SUM_W-1:0] quo_neg;

	// The dividend magnitude shifts out of the top of quo_q into the
	// remainder while quotient bits shift in at the bottom.
	always_comb begin
		shifted = {rem_q, quo_q[SUM_W-1]};
		trial   = shifted - {1'b0, div_q};
		quo_bit = ~trial[WIN_W];
		rem_nxt = quo_bit ? trial[WIN_W-1:0] : shifted[WIN_W-1:0];
		quo_neg = -quo_q;
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			dv_state_q <= DV_IDLE;
			cnt_q      <= '0;
			done_q     <= 1'b0;
		end else begin
			done_q <= 1'b0;
			case (dv_state_q)
				DV_IDLE: begin
					if (start) begin
						cnt_q      <= CNT_W'(SUM_W);
						dv_state_q <= DV_RUN;
					end
				end
				DV_RUN: begin
					cnt_q <= cnt_q - 1'b1;
					if (cnt_q == CNT_W'(1)) begin
						dv_state_q <= DV_FIN;
					end
				end
				DV_FIN: begin
					done_q     <= 1'b1;
					dv_state_q <= DV_IDLE;
				end
				default: begin
					dv_state_q <= DV_IDLE;
				end
			endcase
		end
	end

	always_ff @(posedge clk) begin
		case (dv_state_q)
			DV_IDLE: begin
				if (start) begin
					sign_q <= dividend[SUM_W-1];
					quo_q  <= dividend[SUM_W-1] ? SUM_W'(-dividend) : SUM_W'(dividend);
					rem_q  <= '0;
					div_q  <= divisor;
				end
			end
			DV_RUN: begin
				rem_q <= rem_nxt;
				quo_q <= {quo_q[SUM_W-2:0], quo_bit};
			end
			DV_FIN: begin
				quotient_q <= sign_q ? quo_neg[SB-1:0] : quo_q[SB-1:0];
			end
			default: begin
				rem_q <= rem_q;
			end
		endcase
	end

	assign done     = done_q;
	assign quotient = quotient_q;

	`MMA_ASSERT_NOW(a_start_idle, start, dv_state_q == DV_IDLE, "divider started while busy")
	`MMA_ASSERT_NOW(a_div_nonzero, start, divisor != '0, "divider started with zero window")
	`MMA_ASSERT_NOW(a_rem_bound, dv_state_q == DV_RUN, rem_q < div_q, "remainder not below window")

endmodule
